// ===== design/tcg_pkg.sv =====
// Shared types, codes and defaults for the text console character grid.
package tcg_pkg;

	// Default geometry
	localparam int COLS_DEF     = 80;
	localparam int ROWS_DEF     = 33;
	localparam int TAB_STEP_DEF = 3;

	// Port field widths
	localparam int MODE_W = 2;
	localparam int CODE_W = 9;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Character codes
	localparam logic [CODE_W-1:0] NEWLINE_CODE = 9'd10;
	localparam logic [CODE_W-1:0] TAB_CODE     = 9'd9;
	localparam logic [CODE_W-1:0] BS_CODE      = 9'd8;
	localparam logic [CODE_W-1:0] BS_ALT_CODE  = 9'h100;
	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_READ
	} state_t;

	// Row map update command
	typedef struct packed {
		logic clear_all;
		logic scroll;
		logic set_valid;
	} map_cmd_t;

endpackage

// ===== design/tcg_grid_ram.sv =====
// Character cell memory: one write port, one registered read port.
module tcg_grid_ram import tcg_pkg::*; #(
	parameter int DEPTH = ROWS_DEF * 128,
	parameter int AW    = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CHAR_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/tcg_row_map.sv =====
// Logical-to-physical row map: ring base for scrolling, per-row valid bits for blanking.
module tcg_row_map import tcg_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int RW   = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  map_cmd_t      cmd,
	input  logic [RW-1:0] set_row,
	input  logic [RW-1:0] lrow_a,
	input  logic [RW-1:0] lrow_b,
	output logic [RW-1:0] prow_a,
	output logic [RW-1:0] prow_b,
	output logic          valid_a,
	output logic          valid_b
);

	logic [RW-1:0]   base_q;
	logic [ROWS-1:0] rv_q;
	logic [ROWS-1:0] set_mask;
	logic [ROWS-1:0] clr_mask;

	function automatic logic [RW-1:0] to_phys(input logic [RW-1:0] lrow,
		input logic [RW-1:0] base);
		logic [RW:0] sum;
		sum = {1'b0, lrow} + {1'b0, base};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return sum[RW-1:0];
	endfunction

	assign prow_a  = to_phys(lrow_a, base_q);
	assign prow_b  = to_phys(lrow_b, base_q);
	assign valid_a = rv_q[prow_a];
	assign valid_b = rv_q[prow_b];

	assign set_mask = cmd.set_valid ? (ROWS'(1) << set_row) : '0;
	// old top row becomes the blank bottom row
	assign clr_mask = cmd.scroll ? (ROWS'(1) << base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			rv_q   <= '0;
		end else if (cmd.clear_all) begin
			base_q <= '0;
			rv_q   <= '0;
		end else begin
			rv_q <= (rv_q | set_mask) & ~clr_mask;
			if (cmd.scroll) begin
				base_q <= (base_q == RW'(ROWS-1)) ? '0 : base_q + 1'b1;
			end
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> (rv_q == '0 && base_q == '0))
		else $error("row map not empty after clear");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(base_q) < ROWS)
		else $error("row map base out of range");

	a_scroll_blanks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scroll && !cmd.clear_all) |=> !rv_q[$past(base_q)])
		else $error("scrolled-in row still valid");

	a_set_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_valid && !cmd.clear_all && !(cmd.scroll && set_row == base_q))
		|=> rv_q[$past(set_row)])
		else $error("row not marked valid after write");

endmodule

// ===== design/text_console_char_grid_unit.sv =====
// Text console character grid: top level with request sequencer and cursor.
//
// Requests come in on in_valid/in_ready with mode, char_code, read_row and
// read_col; each request gives exactly one result on out_valid/out_ready
// (cell_char, cursor_column, cursor_line, scrolled). One request is in work
// at a time. The result is registered; a read of a cell in a row that holds
// written data passes through the registered memory read port first. A row
// walk follows a newline or the first write into a blank row: the single
// memory write port blanks the rest of the row, and the result is already
// offered while that walk runs. Other puts, clear, idle mode and reads take
// no walk.
// Scrolling and clearing take no walk: a row map rotates the logical rows and
// keeps one valid bit per row; a row without its bit reads as spaces.
// Reset empties the row map (grid all spaces) and homes the cursor; there is
// no clearing pass. While the result is not taken, a new request may still be
// accepted, but it is held before any state changes until the result
// register is free.
module text_console_char_grid_unit import tcg_pkg::*; #(
	parameter int COLS     = COLS_DEF,
	parameter int ROWS     = ROWS_DEF,
	parameter int TAB_STEP = TAB_STEP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [CODE_W-1:0] char_code,
	input  logic [ROW_W-1:0]  read_row,
	input  logic [COL_W-1:0]  read_col,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] cell_char,
	output logic [COL_W-1:0]  cursor_column,
	output logic [ROW_W-1:0]  cursor_line,
	output logic              scrolled
);

	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int SW    = CW + 5;
	localparam int AW    = RW + CW;
	localparam int DEPTH = ROWS * (2 ** CW);

	state_t state_q, state_d;

	// latched request
	logic [MODE_W-1:0] mode_q;
	logic [CODE_W-1:0] code_q;
	logic [ROW_W-1:0]  rrow_q;
	logic [COL_W-1:0]  rcol_q;

	// cursor
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;

	// row walk
	logic [RW-1:0]     walk_row_q;
	logic [CW-1:0]     walk_col_q;
	logic [CW-1:0]     walk_end_q;
	logic [CW-1:0]     walk_mark_q;
	logic [CHAR_W-1:0] walk_data_q;

	// result register
	logic              out_valid_q;
	logic [CHAR_W-1:0] cell_q;
	logic [CW-1:0]     ocol_q;
	logic [RW-1:0]     orow_q;
	logic              scr_q;

	// row map
	map_cmd_t      cmd;
	logic [RW-1:0] cur_phys;
	logic [RW-1:0] rd_phys;
	logic          cur_valid;
	logic          rd_valid;

	// memory
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CHAR_W-1:0] wdata;
	logic              re;
	logic [CHAR_W-1:0] rdata;

	// decode
	logic              out_free;
	logic              ld_out;
	logic              commit;
	logic              exec_read;
	logic              exec_walk;
	logic              upd_cur;
	logic [CW-1:0]     nxt_col;
	logic [RW-1:0]     nxt_row;
	logic [CHAR_W-1:0] o_cell;
	logic              o_scr;
	logic [CW-1:0]     wk_start;
	logic [CW-1:0]     wk_end;
	logic [CW-1:0]     wk_mark;
	logic [CHAR_W-1:0] wk_data;
	logic              wk_go;
	logic              wrap;
	logic [SW-1:0]     tab_sum;
	logic [CW-1:0]     bs_col;
	logic              rd_in_grid;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign rd_in_grid = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS);
	assign tab_sum    = SW'(cur_col_q) + SW'(TAB_STEP);
	assign bs_col     = (cur_col_q != '0) ? cur_col_q - 1'b1 : '0;

	tcg_row_map #(
		.ROWS (ROWS),
		.RW   (RW)
	) u_row_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.set_row (cur_phys),
		.lrow_a  (cur_row_q),
		.lrow_b  (rrow_q[RW-1:0]),
		.prow_a  (cur_phys),
		.prow_b  (rd_phys),
		.valid_a (cur_valid),
		.valid_b (rd_valid)
	);

	tcg_grid_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_grid_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr ({rd_phys, rcol_q[CW-1:0]}),
		.rdata (rdata)
	);

	// request decode and datapath control
	always_comb begin
		cmd       = '0;
		commit    = 1'b0;
		ld_out    = 1'b0;
		exec_read = 1'b0;
		exec_walk = 1'b0;
		upd_cur   = 1'b0;
		nxt_col   = cur_col_q;
		nxt_row   = cur_row_q;
		o_cell    = '0;
		o_scr     = 1'b0;
		wk_go     = 1'b0;
		wk_start  = cur_col_q;
		wk_end    = cur_col_q;
		wk_mark   = cur_col_q;
		wk_data   = code_q[CHAR_W-1:0];
		wrap      = 1'b0;
		re        = 1'b0;
		we        = 1'b0;
		waddr     = {walk_row_q, walk_col_q};
		wdata     = (walk_col_q == walk_mark_q) ? walk_data_q : SPACE_CHAR;

		case (state_q)
			S_EXEC: begin
				if (out_free) begin
					commit = 1'b1;
					ld_out = 1'b1;
					case (mode_q)
						MODE_PUT: begin
							upd_cur = 1'b1;
							if (code_q == NEWLINE_CODE) begin
								// blank to the row end, mark the cursor cell
								wk_go         = 1'b1;
								cmd.set_valid = 1'b1;
								wk_start      = cur_valid ? cur_col_q : '0;
								wk_end        = CW'(COLS-1);
								wk_data       = NEWLINE_CHAR;
								wrap          = 1'b1;
							end else if (code_q == TAB_CODE) begin
								if (tab_sum >= SW'(COLS)) begin
									wrap = 1'b1;
								end else begin
									nxt_col = tab_sum[CW-1:0];
								end
							end else if (code_q == BS_CODE || code_q == BS_ALT_CODE) begin
								// blank row already reads as spaces
								nxt_col  = bs_col;
								wk_go    = cur_valid;
								wk_start = bs_col;
								wk_end   = bs_col;
								wk_mark  = bs_col;
								wk_data  = SPACE_CHAR;
							end else begin
								// first write into a blank row sweeps the whole row
								wk_go         = 1'b1;
								cmd.set_valid = 1'b1;
								wk_start      = cur_valid ? cur_col_q : '0;
								wk_end        = cur_valid ? cur_col_q : CW'(COLS-1);
								if (cur_col_q == CW'(COLS-1)) begin
									wrap = 1'b1;
								end else begin
									nxt_col = cur_col_q + 1'b1;
								end
							end
							if (wrap) begin
								nxt_col = '0;
								if (cur_row_q == RW'(ROWS-1)) begin
									cmd.scroll = 1'b1;
									o_scr      = 1'b1;
								end else begin
									nxt_row = cur_row_q + 1'b1;
								end
							end
							if (wk_go) begin
								we        = 1'b1;
								waddr     = {cur_phys, wk_start};
								wdata     = (wk_start == wk_mark) ? wk_data : SPACE_CHAR;
								exec_walk = (wk_start != wk_end);
							end
						end
						MODE_READ: begin
							if (rd_in_grid) begin
								if (rd_valid) begin
									re        = 1'b1;
									exec_read = 1'b1;
									ld_out    = 1'b0;
								end else begin
									o_cell = SPACE_CHAR;
								end
							end
						end
						MODE_CLEAR: begin
							upd_cur       = 1'b1;
							nxt_col       = '0;
							nxt_row       = '0;
							cmd.clear_all = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				we = 1'b1;
			end
			S_READ: begin
				ld_out = 1'b1;
				o_cell = rdata;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (commit) begin
					if (exec_read) begin
						state_d = S_READ;
					end else if (exec_walk) begin
						state_d = S_WALK;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_WALK: begin
				if (walk_col_q == walk_end_q) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_cur) begin
				cur_col_q <= nxt_col;
				cur_row_q <= nxt_row;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request latch, walk and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			code_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
		if (commit && exec_walk) begin
			walk_row_q  <= cur_phys;
			walk_col_q  <= wk_start + 1'b1;
			walk_end_q  <= wk_end;
			walk_mark_q <= wk_mark;
			walk_data_q <= wk_data;
		end else if (state_q == S_WALK) begin
			walk_col_q <= walk_col_q + 1'b1;
		end
		if (ld_out) begin
			cell_q <= o_cell;
			ocol_q <= nxt_col;
			orow_q <= nxt_row;
			scr_q  <= o_scr;
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_char     = cell_q;
	assign cursor_column = COL_W'(ocol_q);
	assign cursor_line   = ROW_W'(orow_q);
	assign scrolled      = scr_q;

	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_col_q) < COLS) && (int'(cur_row_q) < ROWS))
		else $error("cursor outside the grid");

	a_read_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && exec_read) |=> (state_q == S_READ && !out_valid_q))
		else $error("read result slot not free");

	a_walk_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (walk_col_q <= walk_end_q))
		else $error("row walk past its end");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("request accepted while busy");

endmodule
